@@ rtl/pba_pkg.sv @@
// Shared types and constants for the PCI BAR and bus allocator.
package pba_pkg;

  localparam logic [1:0] FN_BUS    = 2'd0;
  localparam logic [1:0] FN_BAR    = 2'd1;
  localparam logic [1:0] FN_BRIDGE = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BAD_BAR = 2'd1;
  localparam logic [1:0] ST_NO_BUS  = 2'd2;

  localparam logic [2:0] BAR_MEM32 = 3'b000;
  localparam logic [2:0] BAR_MEM64 = 3'b100;
  localparam logic [63:0] BAR_FLAGS = 64'hF;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_START = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALIGN = 1'b1;

  localparam logic [63:0] START_RESET = 64'd1073741824;
  localparam logic [4:0]  ALIGN_RESET = 5'd20;

  localparam int QUEUE_DEPTH = 2;
  localparam int DIV_STEPS   = 64;

  typedef enum logic [2:0] {
    K_NOP,
    K_MARK,
    K_BAR,
    K_BRIDGE,
    K_BAD_BAR
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  bus;
    logic        first;
    logic        last;
    logic        wide;
    logic [63:0] size;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] bar_value;
    logic        bar_wide;
    logic        base_write;
    logic        limit_write;
    logic [15:0] base;
    logic [15:0] limit;
    logic [7:0]  secondary;
  } res_t;

endpackage

@@ rtl/pba_front.sv @@
// Input acceptance and event classification with BAR size decode.
module pba_front import pba_pkg::*; (
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  func,
  input  logic [7:0]  bus_number,
  input  logic        first_bar,
  input  logic        last_bar,
  input  logic [31:0] probe_low,
  input  logic [31:0] probe_high,
  input  logic        full,
  output logic        push,
  output cmd_t        cmd
);

  logic [2:0]  bar_type;
  logic        wide;
  logic [63:0] probe_full;
  logic [63:0] size_sum;

  assign in_stall = full;
  assign push     = in_valid && !full;

  always_comb begin
    bar_type   = probe_low[2:0];
    wide       = (bar_type == BAR_MEM64);
    probe_full = {(wide ? probe_high : 32'hFFFF_FFFF), probe_low};
    size_sum   = ~(probe_full & ~BAR_FLAGS) + 64'd1;

    cmd.bus   = bus_number;
    cmd.first = first_bar;
    cmd.last  = last_bar;
    cmd.wide  = wide;
    cmd.size  = wide ? size_sum : {32'd0, size_sum[31:0]};

    unique case (func)
      FN_BUS: begin
        cmd.kind = K_MARK;
      end
      FN_BAR: begin
        if (bar_type == BAR_MEM32 || bar_type == BAR_MEM64) begin
          cmd.kind = K_BAR;
        end else begin
          cmd.kind = K_BAD_BAR;
        end
      end
      FN_BRIDGE: begin
        cmd.kind = K_BRIDGE;
      end
      default: begin
        cmd.kind = K_NOP;
      end
    endcase
  end

endmodule

@@ rtl/pba_queue.sv @@
// Short command queue between the classifier and the execution engine.
module pba_queue import pba_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output cmd_t pop_cmd,
  output logic not_empty
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  cmd_t             entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full      = (count == CNT_FULL);
  assign not_empty = (count != '0);
  assign pop_cmd   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

@@ rtl/pba_back.sv @@
// Execution engine: bus bookkeeping, bus search, BAR address rounding and results.
module pba_back import pba_pkg::*; #(
  parameter int BUS_COUNT = 256
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]          cfg_data,
  input  logic                 q_valid,
  input  cmd_t                 q_cmd,
  output logic                 q_pop,
  input  logic                 out_stall,
  output logic                 out_valid,
  output res_t                 res
);

  localparam int IDXW = $clog2(BUS_COUNT);
  localparam int CW   = $clog2(BUS_COUNT + 1);
  localparam int DCW  = $clog2(DIV_STEPS + 1);
  localparam logic [8:0]    BUS_LIM  = 9'(BUS_COUNT);
  localparam logic [CW-1:0] CUR_FULL = CW'(BUS_COUNT);
  localparam logic [DCW-1:0] DIV_LOAD = DCW'(DIV_STEPS);
  localparam logic [IDXW-1:0] IDX_LAST = IDXW'(BUS_COUNT - 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_ALIGN = 3'd2;
  localparam logic [2:0] S_ROUND = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;
  localparam logic [2:0] S_SUB   = 3'd5;
  localparam logic [2:0] S_FIN   = 3'd6;
  localparam logic [2:0] S_WIN   = 3'd7;

  logic [2:0]      state;
  logic            in_use_mem [BUS_COUNT];
  logic            behind_mem [BUS_COUNT];
  logic            opened_mem [BUS_COUNT];
  logic            in_use_rd;
  logic            behind_rd;
  logic            opened_rd;
  logic            clearing;
  logic [IDXW-1:0] clr_idx;
  logic [CW-1:0]   cursor;
  logic [63:0]     next_address;
  logic [63:0]     dev_low;
  logic [4:0]      align_log2;

  cmd_t           cmd;
  logic [8:0]     c;
  logic [63:0]    addr;
  logic [63:0]    smask;
  logic           pow2;
  logic [63:0]    t;
  logic [63:0]    dvd;
  logic [63:0]    rem;
  logic [DCW-1:0] cnt;

  logic            out_free;
  logic            res_load;
  res_t            res_start;
  logic            q_bus_ok;
  logic [IDXW-1:0] q_idx;
  logic [8:0]      bus_p1;
  logic [8:0]      cur9;
  logic [8:0]      scan_start;
  logic [8:0]      c_p1;
  logic [IDXW-1:0] scan_addr;
  logic            c_end;
  logic [IDXW-1:0] c_idx;
  logic            scan_hit;
  logic            mark_wr;
  logic            scan_wr;
  logic            win_wr;
  logic            use_we;
  logic [IDXW-1:0] use_wa;
  logic            use_wd;
  logic            beh_we;
  logic [IDXW-1:0] beh_wa;
  logic            beh_wd;
  logic            opn_we;
  logic [IDXW-1:0] opn_wa;
  logic            opn_wd;
  logic            bus_ok;
  logic [IDXW-1:0] bus_idx;
  logic            bridged;
  logic            win_set;
  logic [63:0]     gmask;
  logic [63:0]     g_round;
  logic [63:0]     size_m1;
  logic [63:0]     t_calc;
  logic            size_zero;
  logic [64:0]     rem_sh;
  logic [64:0]     rem_diff;
  logic [63:0]     low_eff;
  logic [63:0]     low_new;
  logic [63:0]     next_new;
  logic [63:0]     lim;

  assign out_free = !out_valid || !out_stall;
  assign q_pop    = !clearing && (state == S_IDLE) && q_valid && out_free;
  assign res_load = (q_pop && q_cmd.kind != K_BRIDGE && q_cmd.kind != K_BAR) ||
                    ((state == S_SCAN) && (c_end || scan_hit)) || (state == S_WIN);

  always_comb begin
    res_start        = '0;
    res_start.status = (q_cmd.kind == K_BAD_BAR) ? ST_BAD_BAR : ST_OK;
  end

  assign q_bus_ok   = ({1'b0, q_cmd.bus} < BUS_LIM);
  assign q_idx      = q_cmd.bus[IDXW-1:0];
  assign bus_p1     = {1'b0, q_cmd.bus} + 9'd1;
  assign cur9       = 9'(cursor);
  assign scan_start = (cur9 > bus_p1) ? cur9 : bus_p1;
  assign c_p1       = c + 9'd1;
  assign scan_addr  = (state == S_SCAN) ? c_p1[IDXW-1:0] : scan_start[IDXW-1:0];

  assign c_end    = (c >= BUS_LIM);
  assign c_idx    = c[IDXW-1:0];
  assign scan_hit = !c_end && !in_use_rd;

  assign bus_ok  = ({1'b0, cmd.bus} < BUS_LIM);
  assign bus_idx = cmd.bus[IDXW-1:0];
  assign bridged = bus_ok && behind_rd;
  assign win_set = opened_rd;

  assign mark_wr = q_pop && (q_cmd.kind == K_MARK) && q_bus_ok;
  assign scan_wr = (state == S_SCAN) && scan_hit;
  assign win_wr  = (state == S_WIN) && cmd.last && bridged && !win_set;

  assign use_we = clearing || mark_wr || scan_wr;
  assign use_wa = clearing ? clr_idx : ((state == S_SCAN) ? c_idx : q_idx);
  assign use_wd = !clearing;
  assign beh_we = clearing || scan_wr;
  assign beh_wa = clearing ? clr_idx : c_idx;
  assign beh_wd = !clearing;
  assign opn_we = clearing || scan_wr || win_wr;
  assign opn_wa = clearing ? clr_idx : ((state == S_SCAN) ? c_idx : bus_idx);
  assign opn_wd = !clearing && (state == S_WIN);

  assign gmask     = ~({64{1'b1}} << align_log2);
  assign g_round   = (next_address + gmask) & ~gmask;
  assign size_m1   = cmd.size - 64'd1;
  assign t_calc    = addr + smask;
  assign size_zero = (cmd.size == '0);
  assign rem_sh    = {rem, dvd[63]};
  assign rem_diff  = rem_sh - {1'b0, cmd.size};

  assign low_eff  = cmd.first ? {64{1'b1}} : dev_low;
  assign low_new  = (low_eff == {64{1'b1}}) ? addr : low_eff;
  assign next_new = addr + cmd.size;
  assign lim      = next_address - 64'd1;

  always_ff @(posedge clk) begin
    if (use_we) begin
      in_use_mem[use_wa] <= use_wd;
    end
    if (beh_we) begin
      behind_mem[beh_wa] <= beh_wd;
    end
    if (opn_we) begin
      opened_mem[opn_wa] <= opn_wd;
    end
    in_use_rd <= in_use_mem[scan_addr];
    if (q_pop) begin
      behind_rd <= behind_mem[q_idx];
      opened_rd <= opened_mem[q_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      clearing     <= 1'b1;
      clr_idx      <= '0;
      cursor       <= '0;
      next_address <= START_RESET;
      dev_low      <= {64{1'b1}};
      align_log2   <= ALIGN_RESET;
    end else begin
      if (clearing) begin
        if (clr_idx == IDX_LAST) begin
          clearing <= 1'b0;
        end
        clr_idx <= clr_idx + IDXW'(1);
      end
      if (cfg_write) begin
        case (cfg_index)
          CFG_START: next_address <= cfg_data;
          CFG_ALIGN: align_log2   <= cfg_data[4:0];
          default:   ;
        endcase
      end
      unique case (state)
        S_IDLE: begin
          if (q_pop) begin
            unique case (q_cmd.kind)
              K_BRIDGE: state <= S_SCAN;
              K_BAR:    state <= S_ALIGN;
              default:  ;
            endcase
          end
        end
        S_SCAN: begin
          if (c_end) begin
            cursor <= CUR_FULL;
            state  <= S_IDLE;
          end else if (scan_hit) begin
            cursor <= CW'(c_p1);
            state  <= S_IDLE;
          end
        end
        S_ALIGN: begin
          state <= S_ROUND;
        end
        S_ROUND: begin
          state <= (size_zero || pow2) ? S_FIN : S_DIV;
        end
        S_DIV: begin
          if (cnt == DCW'(1)) begin
            state <= S_SUB;
          end
        end
        S_SUB: begin
          state <= S_FIN;
        end
        S_FIN: begin
          next_address <= next_new;
          dev_low      <= low_new;
          state        <= S_WIN;
        end
        S_WIN: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (q_pop) begin
          cmd <= q_cmd;
          c   <= scan_start;
          res <= res_start;
        end
      end
      S_SCAN: begin
        if (c_end) begin
          res.status <= ST_NO_BUS;
        end else if (scan_hit) begin
          res.secondary <= c[7:0];
        end else begin
          c <= c_p1;
        end
      end
      S_ALIGN: begin
        addr  <= (cmd.first && bridged && !win_set) ? g_round : next_address;
        smask <= size_m1;
        pow2  <= ((cmd.size & size_m1) == '0);
      end
      S_ROUND: begin
        t   <= t_calc;
        dvd <= t_calc;
        rem <= '0;
        cnt <= DIV_LOAD;
        if (!size_zero && pow2) begin
          addr <= t_calc & ~smask;
        end
      end
      S_DIV: begin
        rem <= rem_diff[64] ? rem_sh[63:0] : rem_diff[63:0];
        dvd <= {dvd[62:0], 1'b0};
        cnt <= cnt - DCW'(1);
      end
      S_SUB: begin
        addr <= t - rem;
      end
      S_WIN: begin
        res.status    <= ST_OK;
        res.bar_value <= cmd.wide ? addr : {32'd0, addr[31:0]};
        res.bar_wide  <= cmd.wide;
        if (cmd.last && bridged) begin
          if (!win_set) begin
            res.base_write <= 1'b1;
            res.base       <= dev_low[31:16];
          end
          res.limit_write <= 1'b1;
          res.limit       <= lim[31:16];
        end
      end
      default: ;
    endcase
  end

`ifndef SYNTH
  a_busy_no_result: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !out_valid)
    else $error("result register holds a transfer while a command is in flight");

  a_scan_alloc: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && scan_hit) |=>
      (out_valid && cursor == CW'($past(c_p1)) && res.secondary == $past(c[7:0])))
    else $error("allocated secondary bus not recorded");

  a_scan_fail: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && c_end) |=>
      (cursor == CUR_FULL && out_valid && res.status == ST_NO_BUS))
    else $error("failed bus search not reported");

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (rem < cmd.size))
    else $error("partial remainder reached the BAR size");
`endif

endmodule

@@ rtl/pci_bar_and_bus_allocator_unit.sv @@
// Top level of the PCI enumeration BAR address and bus number allocator.
//
//   Channel   Direction  Handshake            Contents
//   input     in         in_valid/in_stall    func, bus_number, first_bar, last_bar, probes
//   output    out        out_valid/out_stall  status, bar_value, bar_wide, window fields, bus
//   config    in         cfg_write            cfg_index, cfg_data (no read-back)
//
// A bus-present event, an unsupported BAR and an unused selector are finished in the idle state.
// A bridge event runs an upward search for a free secondary bus that skips each used bus.
// A BAR with a power-of-two or zero size skips the division; any other size adds the 64-step
// remainder loop and one subtract.
// A two-entry command queue lets input transfers continue while the engine or output stalls.
// Reset is synchronous; it loads the default start and granule, then the engine clears its
// bus tables before it takes the first command.
module pci_bar_and_bus_allocator_unit import pba_pkg::*; #(
  parameter int BUS_COUNT = 256
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]          cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           func,
  input  logic [7:0]           bus_number,
  input  logic                 first_bar,
  input  logic                 last_bar,
  input  logic [31:0]          probe_low,
  input  logic [31:0]          probe_high,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [1:0]           status,
  output logic [63:0]          bar_value,
  output logic                 bar_wide,
  output logic                 window_base_write,
  output logic                 window_limit_write,
  output logic [15:0]          window_base,
  output logic [15:0]          window_limit,
  output logic [7:0]           secondary_bus
);

  logic push;
  logic full;
  cmd_t front_cmd;
  logic q_pop;
  logic q_valid;
  cmd_t q_cmd;
  res_t res;

  pba_front u_front (
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .func       (func),
    .bus_number (bus_number),
    .first_bar  (first_bar),
    .last_bar   (last_bar),
    .probe_low  (probe_low),
    .probe_high (probe_high),
    .full       (full),
    .push       (push),
    .cmd        (front_cmd)
  );

  pba_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_cmd  (front_cmd),
    .full      (full),
    .pop       (q_pop),
    .pop_cmd   (q_cmd),
    .not_empty (q_valid)
  );

  pba_back #(
    .BUS_COUNT (BUS_COUNT)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .res       (res)
  );

  assign status             = res.status;
  assign bar_value          = res.bar_value;
  assign bar_wide           = res.bar_wide;
  assign window_base_write  = res.base_write;
  assign window_limit_write = res.limit_write;
  assign window_base        = res.base;
  assign window_limit       = res.limit;
  assign secondary_bus      = res.secondary;

endmodule
